[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every edge outside reset
`define ASSERT_CLK(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// checked on every edge, reset included
`define ASSERT_CLK_ALWAYS(name, prop, msg) \
	name: assert property (@(posedge clk) (prop)) \
		else $error(msg);

`endif

[hw/rtl/omt_pkg.sv]
// ----------------------------------------------------------------------------
// omt_pkg
// widths, codes and state types of the ordered member table
// ----------------------------------------------------------------------------
package omt_pkg;

	localparam int OMT_DEPTH = 16;

	localparam int KIND_W    = 3;
	localparam int ID_W      = 31;
	localparam int NAME_W    = 64;
	localparam int IDX_W     = 4;
	localparam int STAT_W    = 2;
	localparam int CNT_W     = 5;
	localparam int ENTRY_W   = ID_W + NAME_W;
	localparam int S_TDATA_W = 104;
	localparam int M_TDATA_W = 104;

	typedef enum logic [KIND_W-1:0] {
		KIND_APPEND      = 3'd0,
		KIND_INSERT_HEAD = 3'd1,
		KIND_DELETE_ID   = 3'd2,
		KIND_REMOVE_TAIL = 3'd3,
		KIND_REMOVE_HEAD = 3'd4,
		KIND_READ_INDEX  = 3'd5
	} kind_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_EMPTY = 2'd2,
		STAT_MISS  = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SHIFT,
		ST_SCAN,
		ST_CAPTURE,
		ST_FINISH
	} state_t;

endpackage

[hw/rtl/ordered_member_table_core.sv]
// ----------------------------------------------------------------------------
// ordered_member_table_core
// ordered table of up to DEPTH entries with index reads, head/tail edits and keyed delete
// ----------------------------------------------------------------------------
// One word is taken at a time and gives one result word. Entries live in a
// single entry memory with one write and one registered read per cycle, and
// every edit that moves entries sweeps through it one position a cycle.
// An append, an insert into an empty table or any refused operation goes
// straight to the result; a read by index or a tail removal first reads
// the entry; a head insert into a table that is not empty moves each entry
// up from the tail, then writes position 0; a keyed delete or a head removal
// scans from position 0. The next word is taken in the cycle after
// the result enters the output register. No clearing is needed after reset:
// the table simply starts empty.
// ----------------------------------------------------------------------------
module ordered_member_table_core
	import omt_pkg::*;
#(
	parameter int DEPTH = OMT_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,  // member_id, name_word, read_index
	input  logic [KIND_W-1:0]    s_tuser,  // kind
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,  // member_count, entry_id, entry_name
	output logic [STAT_W-1:0]    m_tuser   // status
);

	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW    = $clog2(DEPTH + 1);
	localparam int CMP_W = (CW > IDX_W) ? CW : IDX_W;

	// input word fields
	kind_t              in_kind;
	logic [ID_W-1:0]    in_id;
	logic [NAME_W-1:0]  in_name;
	logic [IDX_W-1:0]   in_idx;

	assign in_kind = kind_t'(s_tuser);
	assign in_id   = s_tdata[ID_W-1:0];
	assign in_name = s_tdata[ID_W +: NAME_W];
	assign in_idx  = s_tdata[ID_W + NAME_W +: IDX_W];

	// control state
	state_t             state_q, state_d;
	logic [CW-1:0]      count_q;
	logic [AW-1:0]      ptr_q;
	logic               issuing_q;
	logic               found_q;
	logic               rd_vld_s1;
	logic [AW-1:0]      rd_pos_s1;
	logic [ENTRY_W-1:0] rd_data_s1;
	logic               m_tvalid_q;

	// item payload and result
	kind_t              kind_q;
	logic [ID_W-1:0]    key_q;
	logic [NAME_W-1:0]  word_q;
	status_t            res_status_q;
	logic [ID_W-1:0]    res_id_q;
	logic [NAME_W-1:0]  res_name_q;
	logic [M_TDATA_W-1:0] out_data_q;
	logic [STAT_W-1:0]  out_user_q;

	// entry memory
	logic [ENTRY_W-1:0] mem [DEPTH];
	logic               mem_we;
	logic [AW-1:0]      mem_wa;
	logic [ENTRY_W-1:0] mem_wd;
	logic               mem_re;
	logic [AW-1:0]      mem_ra;

	logic               accept;
	logic               full;
	logic               empty;
	logic               idx_out;
	status_t            accept_status;
	state_t             accept_state;
	logic               hit;
	logic               sweep_done;
	logic               out_load;
	logic               cnt_inc;
	logic               cnt_dec;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign idx_out = (CMP_W'(in_idx) >= CMP_W'(count_q));
	assign accept  = s_tvalid && s_tready;

	assign hit = rd_vld_s1 && !found_q &&
		((kind_q == KIND_REMOVE_HEAD) ? (rd_pos_s1 == '0)
		                              : (rd_data_s1[ID_W-1:0] == key_q));

	assign sweep_done = !issuing_q && !rd_vld_s1;

	// next state, memory control and handshake
	always_comb begin
		state_d       = state_q;
		s_tready      = (state_q == ST_IDLE);
		mem_we        = 1'b0;
		mem_wa        = '0;
		mem_wd        = rd_data_s1;
		mem_re        = 1'b0;
		mem_ra        = '0;
		out_load      = 1'b0;
		cnt_inc       = 1'b0;
		cnt_dec       = 1'b0;
		accept_status = STAT_OK;
		accept_state  = ST_FINISH;

		case (in_kind)
			KIND_APPEND: begin
				if (full) begin
					accept_status = STAT_FULL;
				end
			end
			KIND_INSERT_HEAD: begin
				if (full) begin
					accept_status = STAT_FULL;
				end else if (!empty) begin
					accept_state = ST_SHIFT;
				end
			end
			KIND_DELETE_ID, KIND_REMOVE_HEAD: begin
				if (empty) begin
					accept_status = STAT_EMPTY;
				end else begin
					accept_state = ST_SCAN;
				end
			end
			KIND_REMOVE_TAIL: begin
				if (empty) begin
					accept_status = STAT_EMPTY;
				end else begin
					accept_state = ST_CAPTURE;
				end
			end
			KIND_READ_INDEX: begin
				if (empty) begin
					accept_status = STAT_EMPTY;
				end else if (idx_out) begin
					accept_status = STAT_MISS;
				end else begin
					accept_state = ST_CAPTURE;
				end
			end
			default: begin
				accept_status = STAT_OK;
			end
		endcase

		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					state_d = accept_state;
					if (accept_status == STAT_OK) begin
						case (in_kind)
							KIND_APPEND: begin
								mem_we  = 1'b1;
								mem_wa  = AW'(count_q);
								mem_wd  = {in_name, in_id};
								cnt_inc = 1'b1;
							end
							KIND_INSERT_HEAD: begin
								if (empty) begin
									mem_we  = 1'b1;
									mem_wa  = '0;
									mem_wd  = {in_name, in_id};
									cnt_inc = 1'b1;
								end
							end
							KIND_REMOVE_TAIL: begin
								mem_re = 1'b1;
								mem_ra = AW'(count_q - CW'(1));
							end
							KIND_READ_INDEX: begin
								mem_re = 1'b1;
								mem_ra = AW'(in_idx);
							end
							default: begin
								mem_re = 1'b0;
							end
						endcase
					end
				end
			end
			ST_SHIFT: begin
				if (issuing_q) begin
					mem_re = 1'b1;
					mem_ra = ptr_q;
				end
				if (rd_vld_s1) begin
					mem_we = 1'b1;
					mem_wa = rd_pos_s1 + AW'(1);
				end
				if (sweep_done) begin
					mem_we  = 1'b1;
					mem_wa  = '0;
					mem_wd  = {word_q, key_q};
					cnt_inc = 1'b1;
					state_d = ST_FINISH;
				end
			end
			ST_SCAN: begin
				if (issuing_q) begin
					mem_re = 1'b1;
					mem_ra = ptr_q;
				end
				if (rd_vld_s1 && found_q) begin
					mem_we = 1'b1;
					mem_wa = rd_pos_s1 - AW'(1);
				end
				if (sweep_done) begin
					cnt_dec = found_q;
					state_d = ST_FINISH;
				end
			end
			ST_CAPTURE: begin
				cnt_dec = (kind_q == KIND_REMOVE_TAIL);
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (!m_tvalid_q || m_tready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			ptr_q      <= '0;
			issuing_q  <= 1'b0;
			found_q    <= 1'b0;
			rd_vld_s1  <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			rd_vld_s1 <= mem_re;
			if (cnt_inc) begin
				count_q <= count_q + CW'(1);
			end else if (cnt_dec) begin
				count_q <= count_q - CW'(1);
			end
			if (accept) begin
				found_q   <= 1'b0;
				issuing_q <= (accept_state == ST_SHIFT) || (accept_state == ST_SCAN);
				if (accept_state == ST_SHIFT) begin
					ptr_q <= AW'(count_q - CW'(1));
				end else begin
					ptr_q <= '0;
				end
			end else if (state_q == ST_SHIFT && issuing_q) begin
				if (ptr_q == '0) begin
					issuing_q <= 1'b0;
				end else begin
					ptr_q <= ptr_q - AW'(1);
				end
			end else if (state_q == ST_SCAN) begin
				if (hit) begin
					found_q <= 1'b1;
				end
				if (issuing_q) begin
					if (CW'(ptr_q) == count_q - CW'(1)) begin
						issuing_q <= 1'b0;
					end else begin
						ptr_q <= ptr_q + AW'(1);
					end
				end
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// item and result payload
	always_ff @(posedge clk) begin
		rd_pos_s1 <= mem_ra;
		if (accept) begin
			kind_q       <= in_kind;
			key_q        <= in_id;
			word_q       <= in_name;
			res_status_q <= accept_status;
			res_id_q     <= '0;
			res_name_q   <= '0;
		end
		if (state_q == ST_SCAN) begin
			if (hit) begin
				res_id_q   <= rd_data_s1[ID_W-1:0];
				res_name_q <= rd_data_s1[ID_W +: NAME_W];
			end
			if (sweep_done) begin
				res_status_q <= found_q ? STAT_OK : STAT_MISS;
			end
		end
		if (state_q == ST_CAPTURE) begin
			res_id_q   <= rd_data_s1[ID_W-1:0];
			res_name_q <= rd_data_s1[ID_W +: NAME_W];
		end
		if (out_load) begin
			out_user_q <= res_status_q;
			out_data_q <= M_TDATA_W'({res_name_q, res_id_q, CNT_W'(count_q)});
		end
	end

	// entry memory, registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			rd_data_s1 <= mem[mem_ra];
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;

`include "assert_macros.svh"

	`ASSERT_CLK_ALWAYS(a_count_bound, count_q <= CW'(DEPTH), "entry count past depth")
	`ASSERT_CLK(a_full_status,
		(state_q == ST_FINISH && res_status_q == STAT_FULL) |-> full,
		"full status on a table that is not full")
	`ASSERT_CLK(a_read_in_range, rd_vld_s1 |-> (CW'(rd_pos_s1) < count_q),
		"read of an entry past the count")
	`ASSERT_CLK(a_no_rw_clash, (mem_we && mem_re) |-> (mem_wa != mem_ra),
		"read and write of one entry in one cycle")

endmodule
